// File: design/rics_pkg.sv
// ----------------------------------------------------------------------------
// rics_pkg
// Shared types and constants of the Rayleigh inverse-CDF sampler.
// ----------------------------------------------------------------------------
package rics_pkg;

  localparam int unsigned PROB_BITS_DEF     = 32;
  localparam int unsigned OUT_FRAC_BITS_DEF = 16;

  localparam int unsigned LOG_FRAC   = 48;
  localparam int unsigned Y_FRAC     = 56;
  localparam int unsigned S_FRAC     = 28;
  localparam int unsigned SIGMA_FRAC = 16;
  localparam int unsigned SQRT_STEPS = 32;

  localparam logic [63:0] TWO_LN2_Q62 = 64'h58B9_0BFB_E8E7_BCD6;
  localparam logic [23:0] SIGMA_RESET = 24'd65536;
  localparam logic [31:0] GAMMA_RESET = 32'd0;

  typedef enum logic {
    REG_SIGMA = 1'b0,
    REG_GAMMA = 1'b1
  } rics_reg_e;

  typedef struct packed {
    logic [31:0] prob_in;
    logic        tail_flag;
  } rics_req_t;

  typedef struct packed {
    logic signed [31:0] quantile_out;
    logic               overflow_flag;
  } rics_rsp_t;

  typedef struct packed {
    logic [23:0]        scale_sigma;
    logic signed [31:0] location_gamma;
  } rics_cfg_t;

endpackage

// File: design/rics_cfg.sv
// ----------------------------------------------------------------------------
// rics_cfg
// APB register file holding scale sigma and location gamma.
// ----------------------------------------------------------------------------
module rics_cfg import rics_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output rics_cfg_t   cfg_o
);

  logic [23:0] sigma_q;
  logic [31:0] gamma_q;
  rics_reg_e   sel;

  assign sel    = rics_reg_e'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= SIGMA_RESET;
      gamma_q <= GAMMA_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_SIGMA: sigma_q <= pwdata[23:0];
        REG_GAMMA: gamma_q <= pwdata;
        default:   sigma_q <= sigma_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_SIGMA: prdata = {8'd0, sigma_q};
      REG_GAMMA: prdata = gamma_q;
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.scale_sigma    = sigma_q;
  assign cfg_o.location_gamma = $signed(gamma_q);

endmodule

// File: design/rics_log2.sv
// ----------------------------------------------------------------------------
// rics_log2
// Pipelined log2: leading-one search, normalize, one squaring per bit.
// ----------------------------------------------------------------------------
module rics_log2 import rics_pkg::*; #(
  parameter  int unsigned PROB_BITS = PROB_BITS_DEF,
  localparam int unsigned MW        = PROB_BITS + 1,
  localparam int unsigned EW        = $clog2(MW)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [MW-1:0]       m_i,
  input  logic                tag_i,
  output logic                valid_o,
  output logic [EW-1:0]       e_o,
  output logic [LOG_FRAC-1:0] f_o,
  output logic                tag_o
);

  logic          v0_q, v1_q, t0_q, t1_q;
  logic [MW-1:0] m0_q, m1_q;
  logic [EW-1:0] e_d, e1_q;
  logic [5:0]    sh;
  logic [62:0]   x_d;

  logic [62:0]         x_q  [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] f_q  [LOG_FRAC+1];
  logic [EW-1:0]       e_q  [LOG_FRAC+1];
  logic                v_q  [LOG_FRAC+1];
  logic                t_q  [LOG_FRAC+1];

  always_comb begin
    e_d = '0;
    for (int i = 0; i < MW; i++) begin
      if (m0_q[i]) e_d = EW'(i);
    end
  end

  assign sh  = 6'd62 - 6'(e1_q);
  assign x_d = 63'({{(63 - MW){1'b0}}, m1_q} << sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v0_q   <= valid_i;
      v1_q   <= v0_q;
      v_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q   <= m_i;
      t0_q   <= tag_i;
      m1_q   <= m0_q;
      e1_q   <= e_d;
      t1_q   <= t0_q;
      x_q[0] <= x_d;
      e_q[0] <= e1_q;
      f_q[0] <= '0;
      t_q[0] <= t1_q;
    end
  end

  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
    logic [61:0]         phh_q;
    logic [62:0]         phl_q;
    logic [63:0]         pll_q;
    logic                va_q, ta_q;
    logic [LOG_FRAC-1:0] fa_q;
    logic [EW-1:0]       ea_q;
    logic [125:0]        sum;
    logic [63:0]         sq;
    logic [62:0]         x_n;
    logic [LOG_FRAC-1:0] f_n;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q       <= 1'b0;
        v_q[g + 1] <= 1'b0;
      end else if (en_i) begin
        va_q       <= v_q[g];
        v_q[g + 1] <= va_q;
      end
    end

    assign sum = 126'({phh_q, 64'd0}) + 126'({phl_q, 33'd0}) + 126'(pll_q);
    assign sq  = sum[125:62];

    always_comb begin
      f_n = fa_q;
      f_n[LOG_FRAC - 1 - g] = sq[63];
      x_n = sq[63] ? sq[63:1] : sq[62:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        phh_q      <= 62'(x_q[g][62:32] * x_q[g][62:32]);
        phl_q      <= 63'(x_q[g][62:32] * x_q[g][31:0]);
        pll_q      <= x_q[g][31:0] * x_q[g][31:0];
        fa_q       <= f_q[g];
        ea_q       <= e_q[g];
        ta_q       <= t_q[g];
        x_q[g + 1] <= x_n;
        f_q[g + 1] <= f_n;
        e_q[g + 1] <= ea_q;
        t_q[g + 1] <= ta_q;
      end
    end
  end

  assign valid_o = v_q[LOG_FRAC];
  assign e_o     = e_q[LOG_FRAC];
  assign f_o     = f_q[LOG_FRAC];
  assign tag_o   = t_q[LOG_FRAC];

endmodule

// File: design/rics_sqrt.sv
// ----------------------------------------------------------------------------
// rics_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rics_sqrt import rics_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] y_i,
  input  logic        tag_i,
  output logic        valid_o,
  output logic [31:0] s_o,
  output logic        tag_o
);

  logic [63:0] r_q   [SQRT_STEPS];
  logic [63:0] rem_q [SQRT_STEPS];
  logic        v_q   [SQRT_STEPS];
  logic        t_q   [SQRT_STEPS];

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * g);
    logic [63:0] r_c, rem_c, r_n, rem_n;
    logic        v_c, t_c;
    logic [64:0] trial;

    if (g == 0) begin : g_first
      assign r_c   = '0;
      assign rem_c = y_i;
      assign v_c   = valid_i;
      assign t_c   = tag_i;
    end else begin : g_next
      assign r_c   = r_q[g - 1];
      assign rem_c = rem_q[g - 1];
      assign v_c   = v_q[g - 1];
      assign t_c   = t_q[g - 1];
    end

    assign trial = {1'b0, r_c} + {1'b0, Bit};

    always_comb begin
      if ({1'b0, rem_c} >= trial) begin
        rem_n = rem_c - trial[63:0];
        r_n   = (r_c >> 1) + Bit;
      end else begin
        rem_n = rem_c;
        r_n   = r_c >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g]   <= r_n;
        rem_q[g] <= rem_n;
        t_q[g]   <= t_c;
      end
    end
  end

  assign valid_o = v_q[SQRT_STEPS-1];
  assign s_o     = r_q[SQRT_STEPS-1][31:0];
  assign tag_o   = t_q[SQRT_STEPS-1];

endmodule

// File: design/rayleigh_inverse_cdf_sampler_unit.sv
// ----------------------------------------------------------------------------
// rayleigh_inverse_cdf_sampler_unit
// Rayleigh quantile gamma+sigma*sqrt(-2 ln q), Q0.32 p, q = tail ? p : 1-p.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_valid_i/in_ready_o/in_req_i carries the probability
//   and the tail flag; response channel out_valid_o/out_ready_i/out_rsp_o
//   returns the saturated Q16.16 quantile and the overflow flag.
//   Sigma and gamma are to be written over the APB port only while the block
//   is idle; the block itself does not enforce this.
// Throughput: one request per cycle while the output buffer is not full.
// Stages: the log2 squaring chain holds most of them, two per fraction
//   bit (partial products of the 31- and 32-bit halves, then the sum);
//   the square root adds one stage per result bit.
// Reset: pipeline empties, sigma returns to 1.0 and gamma to 0.
// Stall: a two-entry output buffer holds results; the pipeline freezes
//   only when both entries are full, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rayleigh_inverse_cdf_sampler_unit import rics_pkg::*; #(
  parameter int unsigned PROB_BITS     = PROB_BITS_DEF,
  parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rics_req_t   in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rics_rsp_t   out_rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MW = PROB_BITS + 1;
  localparam int unsigned EW = $clog2(MW);
  localparam int unsigned SH = Y_FRAC - S_FRAC + SIGMA_FRAC - OUT_FRAC_BITS;
  localparam logic signed [57:0] MaxRes = 58'sd2147483647;
  localparam logic signed [57:0] MinRes = -58'sd2147483648;

  rics_cfg_t cfg;
  logic      en;

  rics_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  logic [63:0]        u_ext;
  logic [PROB_BITS-1:0] u;
  logic               zero;
  logic [MW-1:0]      m;

  assign u_ext = 64'(in_req_i.prob_in);
  assign u     = u_ext[PROB_BITS-1:0];
  assign zero  = in_req_i.tail_flag && (u == '0);
  assign m     = (in_req_i.tail_flag && !zero) ? MW'(u)
               : (MW'(1) << PROB_BITS) - MW'(u) - (zero ? MW'(0) : MW'(0))
               + (zero ? MW'(1) << PROB_BITS : MW'(0));

  logic                lg_v, lg_t;
  logic [EW-1:0]       lg_e;
  logic [LOG_FRAC-1:0] lg_f;

  rics_log2 #(.PROB_BITS(PROB_BITS)) u_log2 (
    .clk_i, .rst_ni, .en_i (en),
    .valid_i (in_valid_i && in_ready_o), .m_i (m), .tag_i (zero),
    .valid_o (lg_v), .e_o (lg_e), .f_o (lg_f), .tag_o (lg_t)
  );

  logic        l_v_q, a_v_q, y_v_q, vm_v_q, pv_q;
  logic        l_t_q, a_t_q, y_t_q, vm_t_q;
  logic [63:0] l_q, y_q;
  logic [63:0] phh_q, phl_q, plh_q, pll_q;
  logic [127:0] ysum;
  logic [55:0] vm_q;
  rics_rsp_t   pipe_rsp_q;

  assign ysum = {phh_q, 64'd0} + 128'({phl_q, 32'd0}) + 128'({plh_q, 32'd0})
              + 128'(pll_q);

  logic        sq_v, sq_t;
  logic [31:0] sq_s;

  rics_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i (en),
    .valid_i (y_v_q), .y_i (y_q), .tag_i (y_t_q),
    .valid_o (sq_v), .s_o (sq_s), .tag_o (sq_t)
  );

  logic [56:0]        rsum, vr;
  logic signed [57:0] res;
  rics_rsp_t          rsp_d;

  assign rsum = 57'(vm_q) + (57'(1) << (SH - 1));
  assign vr   = rsum >> SH;
  assign res  = $signed({{26{cfg.location_gamma[31]}}, cfg.location_gamma})
              + $signed({1'b0, vr});

  always_comb begin
    if (vm_t_q) begin
      rsp_d.quantile_out  = 32'sh7FFF_FFFF;
      rsp_d.overflow_flag = 1'b1;
    end else if (res > MaxRes) begin
      rsp_d.quantile_out  = 32'sh7FFF_FFFF;
      rsp_d.overflow_flag = 1'b1;
    end else if (res < MinRes) begin
      rsp_d.quantile_out  = $signed(32'h8000_0000);
      rsp_d.overflow_flag = 1'b1;
    end else begin
      rsp_d.quantile_out  = res[31:0];
      rsp_d.overflow_flag = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_v_q  <= 1'b0;
      a_v_q  <= 1'b0;
      y_v_q  <= 1'b0;
      vm_v_q <= 1'b0;
      pv_q   <= 1'b0;
    end else if (en) begin
      l_v_q  <= lg_v;
      a_v_q  <= l_v_q;
      y_v_q  <= a_v_q;
      vm_v_q <= sq_v;
      pv_q   <= vm_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_q        <= ((64'(PROB_BITS) - 64'(lg_e)) << LOG_FRAC) - 64'(lg_f);
      l_t_q      <= lg_t;
      phh_q      <= l_q[63:32] * TWO_LN2_Q62[63:32];
      phl_q      <= l_q[63:32] * TWO_LN2_Q62[31:0];
      plh_q      <= l_q[31:0] * TWO_LN2_Q62[63:32];
      pll_q      <= l_q[31:0] * TWO_LN2_Q62[31:0];
      a_t_q      <= l_t_q;
      y_q        <= ysum[117:54];
      y_t_q      <= a_t_q;
      vm_q       <= sq_s * cfg.scale_sigma;
      vm_t_q     <= sq_t;
      pipe_rsp_q <= rsp_d;
    end
  end

  // Output buffer: head register plus skid entry.
  logic      ov_q, sv_q, pop, arrive;
  rics_rsp_t out_q, skid_q;

  assign en     = !sv_q;
  assign pop    = ov_q && out_ready_i;
  assign arrive = en && pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (pop) sv_q <= 1'b0;
    end else if (arrive) begin
      if (!ov_q || pop) ov_q <= 1'b1;
      else              sv_q <= 1'b1;
    end else if (pop) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (pop) out_q <= skid_q;
    end else if (arrive) begin
      if (!ov_q || pop) out_q  <= pipe_rsp_q;
      else              skid_q <= pipe_rsp_q;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = ov_q;
  assign out_rsp_o   = out_q;

endmodule
